// ===== rtl/core/cotr_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock offset tracker package
// Shared types, constants and saturation helpers for the clock offset tracker.
// ----------------------------------------------------------------------------
package cotr_pkg;

  // Unsigned 48-bit time, signed 48-bit offset, signed 50-bit working value.
  typedef logic [47:0]        time_t;
  typedef logic signed [47:0] soff_t;
  typedef logic signed [49:0] wide_t;

  // Action codes of an input request.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_PING  = 2'd1;
  localparam logic [1:0] ACT_REPLY = 2'd2;

  // Configuration register decode (address bit 2 selects the register).
  localparam logic REG_SLEW = 1'b0;
  localparam logic [19:0] SLEW_RESET = 20'd2000;

  // Schedule constants in microseconds.
  localparam wide_t START_DELAY_US = 50'sd50000;
  localparam wide_t PING_BASE_US   = 50'sd100000;
  localparam wide_t PING_MID_US    = 50'sd500000;
  localparam wide_t PING_LONG_US   = 50'sd10000000;
  localparam wide_t MID_AFTER_US   = 50'sd1000000;
  localparam wide_t LONG_AFTER_US  = 50'sd5000000;

  // Operand bundle for the shared adder.
  typedef struct packed {
    wide_t a;
    wide_t b;
    logic  sub;
  } alu_req_t;

  // One history entry: round trip and offset estimate.
  typedef struct packed {
    soff_t rtt;
    soff_t est;
  } hist_entry_t;

  // Sign-extend a 48-bit offset to the working width.
  function automatic wide_t sext48(input soff_t v);
    return {{2{v[47]}}, v};
  endfunction

  // Zero-extend a 48-bit time to the working width.
  function automatic wide_t zext48(input time_t v);
    return {2'b00, v};
  endfunction

  // Saturate a working value to 48-bit signed.
  function automatic soff_t sat48(input wide_t v);
    soff_t r;
    if ((v[49:47] == 3'b000) || (v[49:47] == 3'b111)) begin
      r = v[47:0];
    end else if (v[49]) begin
      r = {1'b1, 47'd0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

  // Saturate a non-negative working value to 48-bit unsigned.
  function automatic time_t usat48(input wide_t v);
    time_t r;
    if (v[49:48] != 2'b00) begin
      r = {48{1'b1}};
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/clock_offset_min_rtt_tracker_core.sv =====
// ----------------------------------------------------------------------------
// Clock offset tracker core
// Estimates the offset of a reference clock from the local clock by keeping
// the reply with the least round trip out of a short history ring.
// ----------------------------------------------------------------------------
// Each request is worked through by a small sequencer around one shared
// 50-bit adder, and the block takes no new request until the current one has
// finished. A start request passes through ST_START and a ping request through
// ST_PING1 and ST_PING2 before ST_PUT loads the output register. A reply that
// does not match the latest ping goes straight to ST_PUT; a matching reply
// passes through ST_RTT, ST_EST1, ST_EST2 and ST_WR, and once the ring is full
// it goes on to scan each history entry through the ring's registered read
// port (ST_RD, ST_CMP), then makes up to four bound and compare passes through
// the shared adder and at most one slew move.
// The result is held in an output register until taken.
module clock_offset_min_rtt_tracker_core #(
  parameter int HISTORY_DEPTH = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input requests
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_action,
  input  logic [47:0]         in_local_time_us,
  input  logic [31:0]         in_reply_id,
  input  logic [47:0]         in_server_time_us,
  input  logic                in_malformed,
  // Results
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [47:0]  out_offset_us,
  output logic                out_synchronized,
  output logic                out_sync_notice,
  output logic [31:0]         out_ping_id,
  output logic [47:0]         out_next_ping_time_us,
  output logic                out_reply_accepted,
  // Configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_PING1 = 4'd2;
  localparam logic [3:0] ST_PING2 = 4'd3;
  localparam logic [3:0] ST_RTT   = 4'd4;
  localparam logic [3:0] ST_EST1  = 4'd5;
  localparam logic [3:0] ST_EST2  = 4'd6;
  localparam logic [3:0] ST_WR    = 4'd7;
  localparam logic [3:0] ST_RD    = 4'd8;
  localparam logic [3:0] ST_CMP   = 4'd9;
  localparam logic [3:0] ST_APPLY = 4'd10;
  localparam logic [3:0] ST_BND   = 4'd11;
  localparam logic [3:0] ST_TST   = 4'd12;
  localparam logic [3:0] ST_MOV   = 4'd13;
  localparam logic [3:0] ST_PUT   = 4'd14;

  // Control and architectural state.
  logic [3:0]              state_r, state_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic                    full_r, full_nxt;
  logic [AW-1:0]           scan_r, scan_nxt;
  logic [1:0]              phase_r, phase_nxt;
  cotr_pkg::soff_t         offset_r, offset_nxt;
  logic                    sync_r, sync_nxt;
  logic                    notice_r, notice_nxt;
  logic                    accepted_r, accepted_nxt;
  logic [31:0]             ping_id_r, ping_id_nxt;
  cotr_pkg::time_t         last_ping_r, last_ping_nxt;
  cotr_pkg::time_t         sync_start_r, sync_start_nxt;
  cotr_pkg::time_t         next_due_r, next_due_nxt;
  logic [19:0]             slew_r;
  logic                    out_valid_r, out_valid_nxt;

  // Working payload.
  cotr_pkg::time_t         now_r, now_nxt;
  cotr_pkg::time_t         server_r, server_nxt;
  cotr_pkg::wide_t         acc_r, acc_nxt;
  cotr_pkg::soff_t         rtt_r, rtt_nxt;
  cotr_pkg::soff_t         est_r, est_nxt;
  cotr_pkg::soff_t         min_r, min_nxt;
  cotr_pkg::soff_t         best_r, best_nxt;

  // Output payload.
  cotr_pkg::soff_t         out_offset_r;
  logic                    out_sync_r;
  logic                    out_notice_r;
  logic [31:0]             out_ping_id_r;
  cotr_pkg::time_t         out_next_r;
  logic                    out_accepted_r;
  logic                    out_load;

  // Shared adder and history ring.
  cotr_pkg::alu_req_t      alu_req;
  cotr_pkg::wide_t         alu_sum;
  logic                    alu_neg;
  logic                    hist_wr;
  cotr_pkg::hist_entry_t   hist_wdata;
  cotr_pkg::hist_entry_t   hist_rdata;
  cotr_pkg::wide_t         step_w;
  cotr_pkg::wide_t         ping_incr;
  logic                    reply_match;
  logic                    cfg_wr;

  cotr_alu u_alu (
    .req (alu_req),
    .sum (alu_sum),
    .neg (alu_neg)
  );

  cotr_hist #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (hist_wr),
    .wr_addr (idx_r),
    .wr_data (hist_wdata),
    .rd_addr (scan_r),
    .rd_data (hist_rdata)
  );

  assign step_w      = {30'd0, slew_r};
  assign reply_match = (in_reply_id == ping_id_r) && !in_malformed;
  assign hist_wdata  = '{rtt: rtt_r, est: est_r};
  assign hist_wr     = (state_r == ST_WR);

  // Ping interval grows with time since the sync start.
  always_comb begin
    if (acc_r > cotr_pkg::LONG_AFTER_US) begin
      ping_incr = cotr_pkg::PING_LONG_US;
    end else if (acc_r > cotr_pkg::MID_AFTER_US) begin
      ping_incr = cotr_pkg::PING_MID_US;
    end else begin
      ping_incr = cotr_pkg::PING_BASE_US;
    end
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_req = '{a: '0, b: '0, sub: 1'b0};
    case (state_r)
      ST_START: begin
        alu_req = '{a: cotr_pkg::zext48(now_r), b: cotr_pkg::START_DELAY_US, sub: 1'b0};
      end
      ST_PING1: begin
        alu_req = '{a: cotr_pkg::zext48(now_r), b: cotr_pkg::zext48(sync_start_r),
                    sub: 1'b1};
      end
      ST_PING2: begin
        alu_req = '{a: cotr_pkg::zext48(now_r), b: ping_incr, sub: 1'b0};
      end
      ST_RTT: begin
        alu_req = '{a: cotr_pkg::zext48(now_r), b: cotr_pkg::zext48(last_ping_r),
                    sub: 1'b1};
      end
      ST_EST1: begin
        alu_req = '{a: cotr_pkg::zext48(server_r), b: cotr_pkg::zext48(now_r),
                    sub: 1'b1};
      end
      ST_EST2: begin
        // Arithmetic shift gives the half round trip rounded toward minus infinity.
        alu_req = '{a: acc_r, b: cotr_pkg::sext48(rtt_r >>> 1), sub: 1'b0};
      end
      ST_CMP: begin
        alu_req = '{a: cotr_pkg::sext48(hist_rdata.rtt), b: cotr_pkg::sext48(min_r),
                    sub: 1'b1};
      end
      ST_BND: begin
        // Phases: est - rtt, est + rtt, est - step, est + step.
        alu_req = '{a: cotr_pkg::sext48(best_r),
                    b: phase_r[1] ? step_w : cotr_pkg::sext48(min_r),
                    sub: !phase_r[0]};
      end
      ST_TST: begin
        if (!phase_r[0]) begin
          alu_req = '{a: cotr_pkg::sext48(offset_r), b: acc_r, sub: 1'b1};
        end else begin
          alu_req = '{a: acc_r, b: cotr_pkg::sext48(offset_r), sub: 1'b1};
        end
      end
      ST_MOV: begin
        alu_req = '{a: cotr_pkg::sext48(offset_r), b: step_w, sub: phase_r[0]};
      end
      default: begin
        alu_req = '{a: '0, b: '0, sub: 1'b0};
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    full_nxt       = full_r;
    scan_nxt       = scan_r;
    phase_nxt      = phase_r;
    offset_nxt     = offset_r;
    sync_nxt       = sync_r;
    notice_nxt     = notice_r;
    accepted_nxt   = accepted_r;
    ping_id_nxt    = ping_id_r;
    last_ping_nxt  = last_ping_r;
    sync_start_nxt = sync_start_r;
    next_due_nxt   = next_due_r;
    now_nxt        = now_r;
    server_nxt     = server_r;
    acc_nxt        = acc_r;
    rtt_nxt        = rtt_r;
    est_nxt        = est_r;
    min_nxt        = min_r;
    best_nxt       = best_r;
    out_load       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          now_nxt      = in_local_time_us;
          server_nxt   = in_server_time_us;
          notice_nxt   = 1'b0;
          accepted_nxt = 1'b0;
          case (in_action)
            cotr_pkg::ACT_START: state_nxt = ST_START;
            cotr_pkg::ACT_PING:  state_nxt = ST_PING1;
            cotr_pkg::ACT_REPLY: state_nxt = reply_match ? ST_RTT : ST_PUT;
            default:             state_nxt = ST_PUT;
          endcase
        end
      end
      ST_START: begin
        next_due_nxt   = cotr_pkg::usat48(alu_sum);
        sync_start_nxt = cotr_pkg::usat48(alu_sum);
        state_nxt      = ST_PUT;
      end
      ST_PING1: begin
        acc_nxt   = alu_sum;
        state_nxt = ST_PING2;
      end
      ST_PING2: begin
        next_due_nxt  = cotr_pkg::usat48(alu_sum);
        ping_id_nxt   = ping_id_r + 32'd1;
        last_ping_nxt = now_r;
        state_nxt     = ST_PUT;
      end
      ST_RTT: begin
        rtt_nxt   = cotr_pkg::sat48(alu_sum);
        state_nxt = ST_EST1;
      end
      ST_EST1: begin
        acc_nxt   = alu_sum;
        state_nxt = ST_EST2;
      end
      ST_EST2: begin
        est_nxt   = cotr_pkg::sat48(alu_sum);
        state_nxt = ST_WR;
      end
      ST_WR: begin
        accepted_nxt = 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt  = '0;
          full_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
        scan_nxt  = '0;
        state_nxt = (full_r || (idx_r == LAST_IDX)) ? ST_RD : ST_PUT;
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // Strict less-than keeps the first entry on ties.
        if ((scan_r == '0) || alu_neg) begin
          min_nxt  = hist_rdata.rtt;
          best_nxt = hist_rdata.est;
        end
        if (scan_r == LAST_IDX) begin
          state_nxt = ST_APPLY;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_APPLY: begin
        if (!sync_r) begin
          offset_nxt = best_r;
          sync_nxt   = 1'b1;
          notice_nxt = 1'b1;
          state_nxt  = ST_PUT;
        end else begin
          phase_nxt = 2'd0;
          state_nxt = ST_BND;
        end
      end
      ST_BND: begin
        acc_nxt   = alu_sum;
        state_nxt = ST_TST;
      end
      ST_TST: begin
        // Clamp to a bound in the first two phases, slew in the last two.
        if (alu_neg) begin
          if (!phase_r[1]) begin
            offset_nxt = cotr_pkg::sat48(acc_r);
            state_nxt  = ST_PUT;
          end else begin
            state_nxt = ST_MOV;
          end
        end else if (phase_r == 2'd3) begin
          offset_nxt = best_r;
          state_nxt  = ST_PUT;
        end else begin
          phase_nxt = phase_r + 2'd1;
          state_nxt = ST_BND;
        end
      end
      ST_MOV: begin
        offset_nxt = cotr_pkg::sat48(alu_sum);
        state_nxt  = ST_PUT;
      end
      ST_PUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Configuration write decode.
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == cotr_pkg::REG_SLEW);

  // Control and architectural state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      full_r       <= 1'b0;
      scan_r       <= '0;
      phase_r      <= 2'd0;
      offset_r     <= '0;
      sync_r       <= 1'b0;
      notice_r     <= 1'b0;
      accepted_r   <= 1'b0;
      ping_id_r    <= '0;
      last_ping_r  <= '0;
      sync_start_r <= '0;
      next_due_r   <= {48{1'b1}};
      slew_r       <= cotr_pkg::SLEW_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      full_r       <= full_nxt;
      scan_r       <= scan_nxt;
      phase_r      <= phase_nxt;
      offset_r     <= offset_nxt;
      sync_r       <= sync_nxt;
      notice_r     <= notice_nxt;
      accepted_r   <= accepted_nxt;
      ping_id_r    <= ping_id_nxt;
      last_ping_r  <= last_ping_nxt;
      sync_start_r <= sync_start_nxt;
      next_due_r   <= next_due_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr) begin
        slew_r <= pwdata[19:0];
      end
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk) begin
    now_r    <= now_nxt;
    server_r <= server_nxt;
    acc_r    <= acc_nxt;
    rtt_r    <= rtt_nxt;
    est_r    <= est_nxt;
    min_r    <= min_nxt;
    best_r   <= best_nxt;
    if (out_load) begin
      out_offset_r   <= offset_r;
      out_sync_r     <= sync_r;
      out_notice_r   <= notice_r;
      out_ping_id_r  <= ping_id_r;
      out_next_r     <= next_due_r;
      out_accepted_r <= accepted_r;
    end
  end

  // Port drive.
  assign in_ready              = (state_r == ST_IDLE);
  assign out_valid             = out_valid_r;
  assign out_offset_us         = out_offset_r;
  assign out_synchronized      = out_sync_r;
  assign out_sync_notice       = out_notice_r;
  assign out_ping_id           = out_ping_id_r;
  assign out_next_ping_time_us = out_next_r;
  assign out_reply_accepted    = out_accepted_r;
  assign pready                = 1'b1;
  assign prdata = (paddr[2] == cotr_pkg::REG_SLEW) ? {12'd0, slew_r} : 32'd0;

  // A first-sync notice only comes with an accepted reply and a synced clock.
  a_notice_implies_sync : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sync_notice |-> out_synchronized && out_reply_accepted)
    else $error("sync notice without an accepted, synchronized reply");

  // Once synchronized, the tracker stays synchronized until reset.
  a_sync_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    sync_r |=> sync_r)
    else $error("synchronized flag dropped");

  // The sequencer is busy in the cycle after it takes a request.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one is in progress");

  // The ping id moves only at the end of a ping request.
  a_ping_id_source : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (ping_id_r != $past(ping_id_r)) |-> $past(state_r) == ST_PING2)
    else $error("ping id changed outside a ping request");

endmodule

// ===== rtl/core/cotr_alu.sv =====
// ----------------------------------------------------------------------------
// Clock offset tracker shared adder
// One 50-bit add/subtract unit used by the sequencer for the schedule, round trip, estimate, bound and slew sums.
// ----------------------------------------------------------------------------
module cotr_alu (
  input  cotr_pkg::alu_req_t req,
  output cotr_pkg::wide_t    sum,
  output logic               neg
);

  // Add or subtract; the sign of a difference serves as the less-than flag.
  always_comb begin
    if (req.sub) begin
      sum = req.a - req.b;
    end else begin
      sum = req.a + req.b;
    end
    neg = sum[49];
  end

endmodule

// ===== rtl/core/cotr_hist.sv =====
// ----------------------------------------------------------------------------
// Clock offset tracker history ring
// Holds round trip and offset estimate pairs, one write and one read a cycle.
// ----------------------------------------------------------------------------
module cotr_hist #(
  parameter int DEPTH = 5
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  cotr_pkg::hist_entry_t    wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output cotr_pkg::hist_entry_t    rd_data
);

  cotr_pkg::hist_entry_t mem_r [DEPTH];
  cotr_pkg::hist_entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
